// ===== src/icaf_pkg.sv =====
package icaf_pkg;

    localparam int CNT_W      = 5;
    localparam int ATAN_LEN   = 24;
    localparam int SQRT_STEPS = 31;
    localparam int SQRT_SHIFT = 28;
    localparam int SQ_W       = 61;
    localparam int MUL_A_W    = 26;
    localparam int MUL_B_W    = 18;
    localparam int PROD_W     = 44;
    localparam int XY_W       = 34;
    localparam int Z_W        = 25;
    localparam int ANGLE_W    = 24;
    localparam int YAW_W      = 17;
    localparam int ERR_W      = 16;
    localparam int CFG_W      = 16;
    localparam int GYRO_DIV   = 131;
    localparam int GYRO_HALF  = 131 * 32768;
    localparam int NUM_SHIFT  = 14;

    localparam logic [CFG_W-1:0] SAMPLE_PERIOD_RST = 16'd524;
    localparam logic [CFG_W-1:0] GYRO_WEIGHT_RST   = 16'd64225;

    typedef enum logic {
        CFG_SAMPLE_PERIOD,
        CFG_GYRO_WEIGHT
    } cfg_index_t;

    typedef enum logic [1:0] {
        AXIS_ROLL,
        AXIS_PITCH,
        AXIS_YAW
    } axis_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LOAD,
        OP_FAIL,
        OP_SQ_FIRST,
        OP_SQ_Z,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CORDIC_INIT,
        OP_CORDIC_STEP,
        OP_ANGLE_STORE,
        OP_FIRST_LOAD,
        OP_GYRO_MUL,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_INC_STORE,
        OP_BLEND_GYRO,
        OP_BLEND_ACC,
        OP_BLEND_STORE,
        OP_YAW,
        OP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t           op;
        axis_t            axis;
        logic [CNT_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic read_ok;
    } dp_status_t;

    // atan(2^-i) in degrees * 2^16, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_deg16(input logic [CNT_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/icaf_sample_if.sv =====
interface icaf_sample_if;
    logic               valid;
    logic               ready;
    logic               read_ok;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;

    modport source (
        output valid, read_ok, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        input  ready
    );
    modport sink (
        input  valid, read_ok, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z,
        output ready
    );
endinterface

// ===== src/icaf_result_if.sv =====
interface icaf_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] roll_out;
    logic signed [23:0] pitch_out;
    logic signed [16:0] yaw_out;
    logic               stale;
    logic [15:0]        error_total;

    modport source (
        output valid, roll_out, pitch_out, yaw_out, stale, error_total,
        input  ready
    );
    modport sink (
        input  valid, roll_out, pitch_out, yaw_out, stale, error_total,
        output ready
    );
endinterface

// ===== src/imu_complementary_attitude_filter_core.sv =====
// Complementary roll/pitch/yaw filter for one six-axis IMU word at a time. Each word
// on sample_in carries raw accel and gyro counts and a read_ok flag; each produces
// exactly one word on result_out with roll, pitch (degrees * 2^ANGLE_FRAC_BITS,
// saturated to 24 bits), yaw (wrapped to +/-180 degrees), a stale flag and the
// saturating count of failed reads. The first good word loads the accelerometer
// angles directly and zeroes yaw; later good words blend gyro-integrated angles with
// the accelerometer angles by gyro_weight/65536 and integrate gyro_z into yaw.
// Rate: one word at a time. The time from accept to accept for a good word is set
// mostly by the bit-serial square root and the CORDIC vectoring loop (one rotation
// per cycle, two angles), all on one shared datapath, followed by the gyro step for
// each axis (the divide by 131 is one reciprocal multiply), a blend for roll and
// pitch and the yaw wrap. The first good word skips the gyro and blend steps, and a
// failed read skips the angle steps as well. A finished word sits in the output
// register, so the next word is accepted while it waits.
// Configuration (cfg_index 0 = sample_period, 1 = gyro_weight) is to be written by the
// user only while the block is idle; the block itself does not enforce this.
module imu_complementary_attitude_filter_core #(
    parameter int CORDIC_STEPS    = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    icaf_sample_if.sink   sample_in,
    icaf_result_if.source result_out,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    icaf_pkg::dp_cmd_t    cmd;
    icaf_pkg::dp_status_t status;

    // sequencer: walks the angle, gyro and blend steps and owns the handshakes
    icaf_controller #(
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .cmd       (cmd),
        .status    (status)
    );

    // datapath: shared multiplier, sqrt, CORDIC, divider, filter state, result word
    icaf_datapath #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .read_ok     (sample_in.read_ok),
        .accel_x     (sample_in.accel_x),
        .accel_y     (sample_in.accel_y),
        .accel_z     (sample_in.accel_z),
        .gyro_x      (sample_in.gyro_x),
        .gyro_y      (sample_in.gyro_y),
        .gyro_z      (sample_in.gyro_z),
        .roll_out    (result_out.roll_out),
        .pitch_out   (result_out.pitch_out),
        .yaw_out     (result_out.yaw_out),
        .stale       (result_out.stale),
        .error_total (result_out.error_total)
    );

endmodule

// ===== src/icaf_datapath.sv =====
module icaf_datapath #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  icaf_pkg::dp_cmd_t       cmd,
    output icaf_pkg::dp_status_t    status,
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [15:0]             cfg_data,
    input  logic                    read_ok,
    input  logic signed [15:0]      accel_x,
    input  logic signed [15:0]      accel_y,
    input  logic signed [15:0]      accel_z,
    input  logic signed [15:0]      gyro_x,
    input  logic signed [15:0]      gyro_y,
    input  logic signed [15:0]      gyro_z,
    output logic signed [23:0]      roll_out,
    output logic signed [23:0]      pitch_out,
    output logic signed [16:0]      yaw_out,
    output logic                    stale,
    output logic [15:0]             error_total
);
    localparam int AW     = icaf_pkg::MUL_A_W;
    localparam int BW     = icaf_pkg::MUL_B_W;
    localparam int PW     = icaf_pkg::PROD_W;
    localparam int SW     = icaf_pkg::SQ_W;
    localparam int XW     = icaf_pkg::XY_W;
    localparam int ZW     = icaf_pkg::Z_W;
    localparam int ANW    = icaf_pkg::ANGLE_W;
    localparam int YW     = icaf_pkg::YAW_W;
    localparam int EW     = icaf_pkg::ERR_W;
    localparam int MAG_W  = 33 + ANGLE_FRAC_BITS;
    localparam int TW     = MAG_W - 16;
    localparam int RND_SH = 16 - ANGLE_FRAC_BITS;
    localparam int BS_W   = PW - 16;
    // divide by 131 as a reciprocal multiply, exact for any TW-bit dividend
    localparam int RCP_SH = TW + 8;
    localparam int RCP_W  = TW + 1;
    localparam int RP_W   = TW + RCP_W;
    localparam longint RCP_L = ((64'sd1 <<< RCP_SH) + icaf_pkg::GYRO_DIV - 1)
                               / icaf_pkg::GYRO_DIV;
    localparam logic [RCP_W-1:0]       RCP      = RCP_W'(RCP_L);
    localparam logic signed [ZW-1:0]   Z_RND    = ZW'(1 << (15 - ANGLE_FRAC_BITS));
    localparam logic signed [23:0]     YAW_HALF = 24'(180 << ANGLE_FRAC_BITS);
    localparam logic signed [23:0]     YAW_FULL = 24'(360 << ANGLE_FRAC_BITS);
    localparam logic signed [BS_W-1:0] SAT_MAX  = BS_W'(8388607);
    localparam logic signed [BS_W-1:0] SAT_MIN  = -BS_W'(8388608);

    // configuration
    logic [15:0] sample_period_reg;
    logic [15:0] gyro_weight_reg;

    // latched sample
    logic               ok_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;

    // arithmetic registers
    logic signed [PW-1:0]  prod_reg, acc_reg;
    logic [SW-1:0]         rem_reg, root_reg, bit_reg;
    logic signed [XW-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0]  z_reg;
    logic                  zero_reg;
    logic [TW-1:0]         div_reg;
    logic signed [ANW-1:0] inc_reg;
    logic signed [ANW-1:0] racc_reg, pacc_reg;

    // filter state
    logic signed [ANW-1:0] roll_reg, pitch_reg;
    logic signed [YW-1:0]  yaw_reg;
    logic [EW-1:0]         fail_reg;

    // result word
    logic signed [ANW-1:0] roll_out_reg, pitch_out_reg;
    logic signed [YW-1:0]  yaw_out_reg;
    logic                  stale_reg;
    logic [EW-1:0]         err_out_reg;

    // combinational
    logic signed [AW-1:0]  mul_a;
    logic signed [BW-1:0]  mul_b;
    logic signed [PW-1:0]  product;
    logic signed [15:0]    g_sel;
    logic signed [16:0]    g_ext, g_abs;
    logic signed [ANW-1:0] angle_sel, accang_sel;
    logic signed [PW-1:0]  sum_pa;
    logic [SW-1:0]         trial;
    logic signed [16:0]    num_sel;
    logic signed [XW-1:0]  xs, ys;
    logic signed [ZW-1:0]  atan_v, z_round;
    logic [MAG_W-1:0]      mag;
    logic [RP_W-1:0]       rcp_prod;
    logic signed [ANW-1:0] q_s;
    logic signed [BS_W-1:0] blend_r;
    logic signed [ANW-1:0] blend_sat;
    logic signed [23:0]    yaw_sum, yaw_w1, yaw_w2;

    assign status.read_ok = ok_reg;

    always_comb
    begin
        case (cmd.axis)
            icaf_pkg::AXIS_ROLL:
            begin
                g_sel      = gx_reg;
                angle_sel  = roll_reg;
                accang_sel = racc_reg;
                num_sel    = 17'(ay_reg);
            end
            icaf_pkg::AXIS_PITCH:
            begin
                g_sel      = gy_reg;
                angle_sel  = pitch_reg;
                accang_sel = pacc_reg;
                num_sel    = -17'(ax_reg);
            end
            default:
            begin
                g_sel      = gz_reg;
                angle_sel  = roll_reg;
                accang_sel = racc_reg;
                num_sel    = 17'(ay_reg);
            end
        endcase
    end

    assign g_ext = 17'(g_sel);
    assign g_abs = g_ext[16] ? -g_ext : g_ext;

    // shared multiplier, product always registered
    always_comb
    begin
        case (cmd.op)
            icaf_pkg::OP_SQ_FIRST:
            begin
                mul_a = (cmd.axis == icaf_pkg::AXIS_ROLL) ? AW'(ax_reg) : AW'(ay_reg);
                mul_b = (cmd.axis == icaf_pkg::AXIS_ROLL) ? BW'(ax_reg) : BW'(ay_reg);
            end
            icaf_pkg::OP_SQ_Z:
            begin
                mul_a = AW'(az_reg);
                mul_b = BW'(az_reg);
            end
            icaf_pkg::OP_GYRO_MUL:
            begin
                mul_a = AW'(g_abs);
                mul_b = BW'({2'b00, sample_period_reg});
            end
            icaf_pkg::OP_BLEND_GYRO:
            begin
                mul_a = AW'(angle_sel) + AW'(inc_reg);
                mul_b = BW'({2'b00, gyro_weight_reg});
            end
            icaf_pkg::OP_BLEND_ACC:
            begin
                mul_a = AW'(accang_sel);
                mul_b = BW'(18'd65536 - {2'b00, gyro_weight_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = PW'(mul_a) * PW'(mul_b);
    assign sum_pa  = acc_reg + prod_reg;

    // square root step
    assign trial = root_reg + bit_reg;

    // CORDIC step
    assign xs      = x_reg >>> cmd.step;
    assign ys      = y_reg >>> cmd.step;
    assign atan_v  = icaf_pkg::atan_deg16(cmd.step);
    assign z_round = z_reg + Z_RND;

    // gyro increment: round-half-up of |g|*dt*2^F over 131*2^16
    assign mag      = (MAG_W'(prod_reg[31:0]) << ANGLE_FRAC_BITS)
                      + MAG_W'(icaf_pkg::GYRO_HALF);
    assign rcp_prod = RP_W'(div_reg) * RP_W'(RCP);
    assign q_s      = ANW'(div_reg);

    // blend round and saturate
    assign blend_r   = BS_W'((sum_pa + PW'(32768)) >>> 16);
    assign blend_sat = (blend_r > SAT_MAX) ? ANW'(SAT_MAX) :
                       (blend_r < SAT_MIN) ? ANW'(SAT_MIN) : ANW'(blend_r);

    // yaw integrate and wrap once each way
    assign yaw_sum = 24'(yaw_reg) + inc_reg;
    assign yaw_w1  = (yaw_sum > YAW_HALF) ? yaw_sum - YAW_FULL : yaw_sum;
    assign yaw_w2  = (yaw_w1 < -YAW_HALF) ? yaw_w1 + YAW_FULL : yaw_w1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= icaf_pkg::SAMPLE_PERIOD_RST;
            gyro_weight_reg   <= icaf_pkg::GYRO_WEIGHT_RST;
            roll_reg          <= '0;
            pitch_reg         <= '0;
            yaw_reg           <= '0;
            fail_reg          <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == icaf_pkg::CFG_SAMPLE_PERIOD)
                    sample_period_reg <= cfg_data;
                else
                    gyro_weight_reg <= cfg_data;
            end
            case (cmd.op)
                icaf_pkg::OP_FAIL:
                begin
                    if (fail_reg != {EW{1'b1}})
                        fail_reg <= fail_reg + 1'b1;
                end
                icaf_pkg::OP_FIRST_LOAD:
                begin
                    roll_reg  <= racc_reg;
                    pitch_reg <= pacc_reg;
                    yaw_reg   <= '0;
                end
                icaf_pkg::OP_BLEND_STORE:
                begin
                    if (cmd.axis == icaf_pkg::AXIS_ROLL)
                        roll_reg <= blend_sat;
                    else
                        pitch_reg <= blend_sat;
                end
                icaf_pkg::OP_YAW:
                    yaw_reg <= YW'(yaw_w2);
                default:
                begin
                end
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        prod_reg <= product;
        case (cmd.op)
            icaf_pkg::OP_LOAD:
            begin
                ok_reg <= read_ok;
                ax_reg <= accel_x;
                ay_reg <= accel_y;
                az_reg <= accel_z;
                gx_reg <= gyro_x;
                gy_reg <= gyro_y;
                gz_reg <= gyro_z;
            end
            icaf_pkg::OP_SQ_Z:
                acc_reg <= prod_reg;
            icaf_pkg::OP_SQRT_INIT:
            begin
                rem_reg  <= SW'(sum_pa[31:0]) << icaf_pkg::SQRT_SHIFT;
                root_reg <= '0;
                bit_reg  <= SW'(1) << (2 * (icaf_pkg::SQRT_STEPS - 1));
            end
            icaf_pkg::OP_SQRT_STEP:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg  <= rem_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            icaf_pkg::OP_CORDIC_INIT:
            begin
                x_reg    <= XW'(root_reg[30:0]);
                y_reg    <= XW'(num_sel) <<< icaf_pkg::NUM_SHIFT;
                z_reg    <= '0;
                zero_reg <= (root_reg == '0) && (num_sel == '0);
            end
            icaf_pkg::OP_CORDIC_STEP:
            begin
                if (!y_reg[XW-1])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + atan_v;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - atan_v;
                end
            end
            icaf_pkg::OP_ANGLE_STORE:
            begin
                if (cmd.axis == icaf_pkg::AXIS_ROLL)
                    racc_reg <= zero_reg ? '0 : ANW'(z_round >>> RND_SH);
                else
                    pacc_reg <= zero_reg ? '0 : ANW'(z_round >>> RND_SH);
            end
            icaf_pkg::OP_DIV_INIT:
                div_reg <= mag[MAG_W-1:16];
            icaf_pkg::OP_DIV_STEP:
                div_reg <= TW'(rcp_prod[RP_W-1:RCP_SH]);
            icaf_pkg::OP_INC_STORE:
                inc_reg <= g_sel[15] ? -q_s : q_s;
            icaf_pkg::OP_BLEND_ACC:
                acc_reg <= prod_reg;
            icaf_pkg::OP_OUT_LOAD:
            begin
                roll_out_reg  <= roll_reg;
                pitch_out_reg <= pitch_reg;
                yaw_out_reg   <= yaw_reg;
                stale_reg     <= !ok_reg;
                err_out_reg   <= fail_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign roll_out    = roll_out_reg;
    assign pitch_out   = pitch_out_reg;
    assign yaw_out     = yaw_out_reg;
    assign stale       = stale_reg;
    assign error_total = err_out_reg;

endmodule

// ===== src/icaf_controller.sv =====
module icaf_controller #(
    parameter int CORDIC_STEPS    = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output icaf_pkg::dp_cmd_t    cmd,
    input  icaf_pkg::dp_status_t status
);
    localparam int CW       = icaf_pkg::CNT_W;
    localparam int N_CORDIC = (CORDIC_STEPS < icaf_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                                  : icaf_pkg::ATAN_LEN;
    localparam logic [CW-1:0] SQRT_LAST   = CW'(icaf_pkg::SQRT_STEPS - 1);
    localparam logic [CW-1:0] CORDIC_LAST = CW'(N_CORDIC - 1);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_FAIL,
        S_SQ_FIRST,
        S_SQ_Z,
        S_SQRT_INIT,
        S_SQRT,
        S_CORDIC_INIT,
        S_CORDIC,
        S_ANGLE,
        S_FIRST,
        S_GYRO_MUL,
        S_DIV_INIT,
        S_DIV,
        S_INC,
        S_BLEND_GYRO,
        S_BLEND_ACC,
        S_BLEND_STORE,
        S_YAW,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    icaf_pkg::axis_t     axis_reg, axis_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic                first_reg, first_next;
    logic                out_valid_reg, out_valid_next;
    icaf_pkg::dp_op_t    op;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    assign cmd.op   = op;
    assign cmd.axis = axis_reg;
    assign cmd.step = cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op             = icaf_pkg::OP_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = icaf_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                axis_next  = icaf_pkg::AXIS_ROLL;
                state_next = status.read_ok ? S_SQ_FIRST : S_FAIL;
            end
            S_FAIL:
            begin
                op         = icaf_pkg::OP_FAIL;
                state_next = S_DONE;
            end
            S_SQ_FIRST:
            begin
                op         = icaf_pkg::OP_SQ_FIRST;
                state_next = S_SQ_Z;
            end
            S_SQ_Z:
            begin
                op         = icaf_pkg::OP_SQ_Z;
                state_next = S_SQRT_INIT;
            end
            S_SQRT_INIT:
            begin
                op         = icaf_pkg::OP_SQRT_INIT;
                cnt_next   = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                op       = icaf_pkg::OP_SQRT_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST)
                    state_next = S_CORDIC_INIT;
            end
            S_CORDIC_INIT:
            begin
                op         = icaf_pkg::OP_CORDIC_INIT;
                cnt_next   = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                op       = icaf_pkg::OP_CORDIC_STEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CORDIC_LAST)
                    state_next = S_ANGLE;
            end
            S_ANGLE:
            begin
                op = icaf_pkg::OP_ANGLE_STORE;
                if (axis_reg == icaf_pkg::AXIS_ROLL)
                begin
                    axis_next  = icaf_pkg::AXIS_PITCH;
                    state_next = S_SQ_FIRST;
                end
                else if (first_reg)
                    state_next = S_FIRST;
                else
                begin
                    axis_next  = icaf_pkg::AXIS_ROLL;
                    state_next = S_GYRO_MUL;
                end
            end
            S_FIRST:
            begin
                op         = icaf_pkg::OP_FIRST_LOAD;
                first_next = 1'b0;
                state_next = S_DONE;
            end
            S_GYRO_MUL:
            begin
                op         = icaf_pkg::OP_GYRO_MUL;
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                op         = icaf_pkg::OP_DIV_INIT;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                op         = icaf_pkg::OP_DIV_STEP;
                state_next = S_INC;
            end
            S_INC:
            begin
                op         = icaf_pkg::OP_INC_STORE;
                state_next = (axis_reg == icaf_pkg::AXIS_YAW) ? S_YAW : S_BLEND_GYRO;
            end
            S_BLEND_GYRO:
            begin
                op         = icaf_pkg::OP_BLEND_GYRO;
                state_next = S_BLEND_ACC;
            end
            S_BLEND_ACC:
            begin
                op         = icaf_pkg::OP_BLEND_ACC;
                state_next = S_BLEND_STORE;
            end
            S_BLEND_STORE:
            begin
                op         = icaf_pkg::OP_BLEND_STORE;
                axis_next  = (axis_reg == icaf_pkg::AXIS_ROLL) ? icaf_pkg::AXIS_PITCH
                                                              : icaf_pkg::AXIS_YAW;
                state_next = S_GYRO_MUL;
            end
            S_YAW:
            begin
                op         = icaf_pkg::OP_YAW;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    op             = icaf_pkg::OP_OUT_LOAD;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            axis_reg      <= icaf_pkg::AXIS_ROLL;
            cnt_reg       <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/icaf_checker.sv =====
module icaf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        stale,
    input logic [15:0] error_total
);
    // a result word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

    // one word at a time: no accept right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("second word accepted while busy");

    // a stale word always reports at least one failure
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stale |-> error_total != 16'd0)
    else $error("stale word with zero failure count");

endmodule

bind imu_complementary_attitude_filter_core icaf_checker u_icaf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample_in.valid),
    .in_ready    (sample_in.ready),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .stale       (result_out.stale),
    .error_total (result_out.error_total)
);
